>>> src/psdm_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and modular helpers for the power series divider
// no dependencies

package psdm_pkg;

    localparam int WORD_BITS     = 64;
    localparam int LEN_BITS      = 9;
    localparam int CFG_DATA_BITS = 64;

    typedef logic [1:0] op_t;
    typedef logic [1:0] status_t;
    typedef logic       cfg_idx_t;

    localparam op_t OP_LOAD_NUM = 2'd0;
    localparam op_t OP_LOAD_DEN = 2'd1;
    localparam op_t OP_COMPUTE  = 2'd2;
    localparam op_t OP_READ     = 2'd3;

    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_DEN_ZERO = 2'd1;
    localparam status_t STATUS_NO_INV   = 2'd2;

    localparam cfg_idx_t REG_MODULUS = 1'b0;
    localparam cfg_idx_t REG_TERMS   = 1'b1;

    // multiplier engine status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } mm_stat_t;

    // (a + b) mod m for a, b below m
    function automatic logic [WORD_BITS-1:0] add_m(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b,
                                                   input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[WORD_BITS-1:0];
    endfunction

    // (a - b) mod m for a, b below m
    function automatic logic [WORD_BITS-1:0] sub_m(input logic [WORD_BITS-1:0] a,
                                                   input logic [WORD_BITS-1:0] b,
                                                   input logic [WORD_BITS-1:0] m);
        logic [WORD_BITS-1:0] d;
        d = a - b;
        if (a < b)
            d = d + m;
        return d;
    endfunction

endpackage

>>> src/power_series_divide_mod_n_unit.sv
`timescale 1ns / 1ps
// power series division mod m: coefficient stores, sequencer, divider for the inverse
// depends on psdm_pkg and psdm_modmul
//
// Usage: write modulus (index 0) and terms (index 1) on the cfg channel while idle;
// cfg_ready is always high. Input items transfer on in_valid high and in_stall low.
// Loads (op 0, 1) write one coefficient and give no result.
// A read (op 3) passes through the states RD_WAIT and PUT to its result.
// A compute (op 2) runs a bit-serial modular multiply for each of the up to
// n(n-1)/2 products, plus up to two per row; the inverse of the leading
// coefficient takes an extended Euclid pass, and the unused tail of the
// quotient store is cleared at one entry a cycle.
// The multiplier is the bottleneck; the block works on one item at a time.
// Results sit in an output register: while out_stall is high the result holds
// and a further load is still taken; a read or compute finishes and waits for it.
// After reset the numerator and denominator stores are cleared with in_stall
// high; cfg writes are taken as ever.

module power_series_divide_mod_n_unit #(
    parameter int MAX_TERMS  = 256,
    parameter int COEFF_BITS = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  psdm_pkg::cfg_idx_t               cfg_index,
    input  logic [psdm_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  psdm_pkg::op_t                    op,
    input  logic [7:0]                       coeff_index,
    input  logic [COEFF_BITS-1:0]            coeff_value,
    input  logic [psdm_pkg::LEN_BITS-1:0]    num_len,
    input  logic [psdm_pkg::LEN_BITS-1:0]    den_len,
    output logic                             out_valid,
    input  logic                             out_stall,
    output psdm_pkg::status_t                status,
    output logic [COEFF_BITS-1:0]            coeff_out
);
    import psdm_pkg::*;

    localparam int IDX_W = $clog2(MAX_TERMS);
    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int CW    = (CNT_W > LEN_BITS) ? CNT_W : LEN_BITS;
    localparam int SW    = $clog2(COEFF_BITS);

    localparam logic [4:0] ST_CLEAR    = 5'd0;
    localparam logic [4:0] ST_IDLE     = 5'd1;
    localparam logic [4:0] ST_RD_WAIT  = 5'd2;
    localparam logic [4:0] ST_D0_WAIT  = 5'd3;
    localparam logic [4:0] ST_D0_MUL   = 5'd4;
    localparam logic [4:0] ST_INV_TEST = 5'd5;
    localparam logic [4:0] ST_DIV      = 5'd6;
    localparam logic [4:0] ST_INV_MUL  = 5'd7;
    localparam logic [4:0] ST_ROW      = 5'd8;
    localparam logic [4:0] ST_MAC_WAIT = 5'd9;
    localparam logic [4:0] ST_MAC_MUL  = 5'd10;
    localparam logic [4:0] ST_NUM_WAIT = 5'd11;
    localparam logic [4:0] ST_NUM_MUL  = 5'd12;
    localparam logic [4:0] ST_Q_MUL    = 5'd13;
    localparam logic [4:0] ST_QCLR     = 5'd14;
    localparam logic [4:0] ST_PUT      = 5'd15;

    // coefficient stores
    logic [COEFF_BITS-1:0] num_mem [MAX_TERMS];
    logic [COEFF_BITS-1:0] den_mem [MAX_TERMS];
    logic [COEFF_BITS-1:0] q_mem   [MAX_TERMS];

    logic                  num_we, den_we, q_we;
    logic [IDX_W-1:0]      num_waddr, den_waddr, q_waddr;
    logic [IDX_W-1:0]      num_raddr, den_raddr, q_raddr;
    logic [COEFF_BITS-1:0] num_wdata, den_wdata, q_wdata;
    logic [COEFF_BITS-1:0] num_rdata_reg, den_rdata_reg, q_rdata_reg;

    logic [4:0]            state_reg;
    logic [COEFF_BITS-1:0] modulus_reg;
    logic [LEN_BITS-1:0]   terms_reg;
    status_t               last_status_reg;

    logic [CW-1:0]         i_reg, j_reg, n_reg, plen_reg, dlen_reg;
    logic                  nlen_zero_reg;
    logic                  res_zero_reg;
    logic [COEFF_BITS-1:0] s_reg;
    logic [COEFF_BITS-1:0] r0_reg, r1_reg, t0_reg, t1_reg;
    logic [COEFF_BITS-1:0] div_rem_reg, div_q_reg;
    logic [SW-1:0]         step_reg;

    logic                  mm_go_reg;
    logic                  mm_go_next;
    logic [COEFF_BITS-1:0] mm_a_reg, mm_b_reg;
    logic [COEFF_BITS-1:0] mm_res;
    mm_stat_t              mm_stat;

    status_t               res_status_reg;
    logic [COEFF_BITS-1:0] res_coeff_reg;
    logic                  out_valid_reg;
    status_t               status_reg;
    logic [COEFF_BITS-1:0] coeff_out_reg;

    logic                  in_accept;
    logic [COEFF_BITS-1:0] m_eff;
    logic [CW-1:0]         cw_max, terms_cw, n_clip, den_cw, dlen0, dlen_clip;
    logic [CW-1:0]         num_cw, plen_clip, idx_cw, l_cur, jp1, qa;
    logic                  idx_ok;
    logic [IDX_W-1:0]      idx_addr;
    logic [COEFF_BITS:0]   div_t, div_sub;
    logic                  div_ge;
    logic [COEFF_BITS-1:0] div_rem_n, div_q_n;
    logic [COEFF_BITS-1:0] s_sub, v_sub, inv_step, s_acc;

    assign in_accept = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign m_eff = (modulus_reg < COEFF_BITS'(2)) ? COEFF_BITS'(2) : modulus_reg;

    // length clipping and index checks
    always_comb
    begin
        cw_max    = CW'(MAX_TERMS);
        terms_cw  = CW'(terms_reg);
        n_clip    = (terms_cw > cw_max) ? cw_max : terms_cw;
        den_cw    = CW'(den_len);
        dlen0     = (den_cw > cw_max) ? cw_max : den_cw;
        dlen_clip = (dlen0 > n_clip) ? n_clip : dlen0;
        num_cw    = CW'(num_len);
        plen_clip = (num_cw > n_clip) ? n_clip : num_cw;
        idx_cw    = CW'(coeff_index);
        idx_ok    = (idx_cw < cw_max);
        idx_addr  = idx_cw[IDX_W-1:0];
        l_cur     = (i_reg < dlen_reg - CW'(1)) ? i_reg : dlen_reg - CW'(1);
        jp1       = j_reg + CW'(1);
        qa        = i_reg - CW'(1) - j_reg;
    end

    // one restoring division step for the Euclid quotient
    always_comb
    begin
        div_t     = {div_rem_reg, div_q_reg[COEFF_BITS-1]};
        div_sub   = div_t - {1'b0, r1_reg};
        div_ge    = (div_t >= {1'b0, r1_reg});
        div_rem_n = div_ge ? div_sub[COEFF_BITS-1:0] : div_t[COEFF_BITS-1:0];
        div_q_n   = {div_q_reg[COEFF_BITS-2:0], div_ge};
    end

    always_comb
    begin
        s_sub    = COEFF_BITS'(sub_m('0, WORD_BITS'(s_reg), WORD_BITS'(m_eff)));
        v_sub    = COEFF_BITS'(sub_m(WORD_BITS'(mm_res), WORD_BITS'(s_reg),
                                     WORD_BITS'(m_eff)));
        inv_step = COEFF_BITS'(sub_m(WORD_BITS'(t0_reg), WORD_BITS'(mm_res),
                                     WORD_BITS'(m_eff)));
        s_acc    = COEFF_BITS'(add_m(WORD_BITS'(s_reg), WORD_BITS'(mm_res),
                                     WORD_BITS'(m_eff)));
    end

    // multiplier start for the next cycle
    always_comb
    begin
        mm_go_next = 1'b0;
        unique case (state_reg)
            ST_D0_WAIT:  mm_go_next = 1'b1;
            ST_MAC_WAIT: mm_go_next = 1'b1;
            ST_NUM_WAIT: mm_go_next = 1'b1;
            ST_DIV:      mm_go_next = (step_reg == SW'(COEFF_BITS - 1));
            ST_ROW:      mm_go_next = (i_reg != n_reg) && !(j_reg < l_cur) &&
                                      !(i_reg < plen_reg);
            ST_NUM_MUL:  mm_go_next = mm_stat.done;
            default:     mm_go_next = 1'b0;
        endcase
    end

    // store port control
    always_comb
    begin
        num_we    = 1'b0;
        den_we    = 1'b0;
        q_we      = 1'b0;
        num_waddr = i_reg[IDX_W-1:0];
        den_waddr = i_reg[IDX_W-1:0];
        q_waddr   = i_reg[IDX_W-1:0];
        num_wdata = '0;
        den_wdata = '0;
        q_wdata   = '0;
        num_raddr = i_reg[IDX_W-1:0];
        den_raddr = jp1[IDX_W-1:0];
        q_raddr   = qa[IDX_W-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                num_we = 1'b1;
                den_we = 1'b1;
            end
            ST_IDLE:
            begin
                num_waddr = idx_addr;
                den_waddr = idx_addr;
                num_wdata = coeff_value;
                den_wdata = coeff_value;
                num_we    = in_accept && (op == OP_LOAD_NUM) && idx_ok;
                den_we    = in_accept && (op == OP_LOAD_DEN) && idx_ok;
                den_raddr = '0;
                q_raddr   = idx_addr;
            end
            ST_Q_MUL:
            begin
                q_we    = mm_stat.done;
                q_wdata = mm_res;
            end
            ST_QCLR:
            begin
                q_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (num_we)
            num_mem[num_waddr] <= num_wdata;
        num_rdata_reg <= num_mem[num_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (den_we)
            den_mem[den_waddr] <= den_wdata;
        den_rdata_reg <= den_mem[den_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (q_we)
            q_mem[q_waddr] <= q_wdata;
        q_rdata_reg <= q_mem[q_raddr];
    end

    psdm_modmul #(
        .COEFF_BITS (COEFF_BITS)
    ) u_modmul (
        .clk    (clk),
        .rst_n  (rst_n),
        .go     (mm_go_reg),
        .a      (mm_a_reg),
        .b      (mm_b_reg),
        .m      (m_eff),
        .result (mm_res),
        .stat   (mm_stat)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg <= COEFF_BITS'(2);
            terms_reg   <= LEN_BITS'(1);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MODULUS: modulus_reg <= cfg_data[COEFF_BITS-1:0];
                REG_TERMS:   terms_reg   <= cfg_data[LEN_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            last_status_reg <= STATUS_OK;
            i_reg           <= '0;
            j_reg           <= '0;
            n_reg           <= '0;
            plen_reg        <= '0;
            dlen_reg        <= '0;
            nlen_zero_reg   <= 1'b0;
            res_zero_reg    <= 1'b0;
            s_reg           <= '0;
            r0_reg          <= '0;
            r1_reg          <= '0;
            t0_reg          <= '0;
            t1_reg          <= '0;
            div_rem_reg     <= '0;
            div_q_reg       <= '0;
            step_reg        <= '0;
            mm_go_reg       <= 1'b0;
            mm_a_reg        <= '0;
            mm_b_reg        <= '0;
            res_status_reg  <= STATUS_OK;
            res_coeff_reg   <= '0;
            out_valid_reg   <= 1'b0;
            status_reg      <= STATUS_OK;
            coeff_out_reg   <= '0;
        end
        else
        begin
            mm_go_reg <= mm_go_next;
            if (out_valid_reg && !out_stall && state_reg != ST_PUT)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (i_reg == cw_max - CW'(1))
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end

                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        unique case (op) inside
                            OP_COMPUTE:
                            begin
                                n_reg         <= n_clip;
                                plen_reg      <= plen_clip;
                                dlen_reg      <= dlen_clip;
                                nlen_zero_reg <= (num_len == '0);
                                if (dlen_clip == '0)
                                begin
                                    res_status_reg  <= STATUS_DEN_ZERO;
                                    last_status_reg <= STATUS_DEN_ZERO;
                                    res_coeff_reg   <= '0;
                                    state_reg       <= ST_PUT;
                                end
                                else
                                    state_reg <= ST_D0_WAIT;
                            end
                            OP_READ:
                            begin
                                res_zero_reg <= !idx_ok;
                                state_reg    <= ST_RD_WAIT;
                            end
                            OP_LOAD_NUM, OP_LOAD_DEN:
                            begin
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end

                ST_RD_WAIT:
                begin
                    res_coeff_reg  <= res_zero_reg ? '0 : q_rdata_reg;
                    res_status_reg <= last_status_reg;
                    state_reg      <= ST_PUT;
                end

                ST_D0_WAIT:
                begin
                    mm_a_reg  <= COEFF_BITS'(1);
                    mm_b_reg  <= den_rdata_reg;
                    state_reg <= ST_D0_MUL;
                end

                ST_D0_MUL:
                begin
                    if (mm_stat.done)
                    begin
                        if (mm_res == '0)
                        begin
                            res_status_reg  <= STATUS_DEN_ZERO;
                            last_status_reg <= STATUS_DEN_ZERO;
                            res_coeff_reg   <= '0;
                            state_reg       <= ST_PUT;
                        end
                        else if (nlen_zero_reg)
                        begin
                            i_reg     <= '0;
                            state_reg <= ST_QCLR;
                        end
                        else
                        begin
                            r0_reg    <= m_eff;
                            r1_reg    <= mm_res;
                            t0_reg    <= '0;
                            t1_reg    <= COEFF_BITS'(1);
                            state_reg <= ST_INV_TEST;
                        end
                    end
                end

                ST_INV_TEST:
                begin
                    if (r1_reg == '0)
                    begin
                        if (r0_reg == COEFF_BITS'(1))
                        begin
                            // t0 now holds the inverse of the leading coefficient
                            i_reg     <= '0;
                            j_reg     <= '0;
                            s_reg     <= '0;
                            state_reg <= ST_ROW;
                        end
                        else
                        begin
                            res_status_reg  <= STATUS_NO_INV;
                            last_status_reg <= STATUS_NO_INV;
                            res_coeff_reg   <= '0;
                            state_reg       <= ST_PUT;
                        end
                    end
                    else
                    begin
                        div_rem_reg <= '0;
                        div_q_reg   <= r0_reg;
                        step_reg    <= '0;
                        state_reg   <= ST_DIV;
                    end
                end

                ST_DIV:
                begin
                    div_rem_reg <= div_rem_n;
                    div_q_reg   <= div_q_n;
                    step_reg    <= step_reg + SW'(1);
                    if (step_reg == SW'(COEFF_BITS - 1))
                    begin
                        mm_a_reg  <= t1_reg;
                        mm_b_reg  <= div_q_n;
                        state_reg <= ST_INV_MUL;
                    end
                end

                ST_INV_MUL:
                begin
                    if (mm_stat.done)
                    begin
                        t1_reg    <= inv_step;
                        t0_reg    <= t1_reg;
                        r0_reg    <= r1_reg;
                        r1_reg    <= div_rem_reg;
                        state_reg <= ST_INV_TEST;
                    end
                end

                ST_ROW:
                begin
                    if (i_reg == n_reg)
                    begin
                        if (n_reg == cw_max)
                        begin
                            res_status_reg  <= STATUS_OK;
                            last_status_reg <= STATUS_OK;
                            res_coeff_reg   <= '0;
                            state_reg       <= ST_PUT;
                        end
                        else
                            state_reg <= ST_QCLR;
                    end
                    else if (j_reg < l_cur)
                        state_reg <= ST_MAC_WAIT;
                    else if (i_reg < plen_reg)
                        state_reg <= ST_NUM_WAIT;
                    else
                    begin
                        mm_a_reg  <= t0_reg;
                        mm_b_reg  <= s_sub;
                        state_reg <= ST_Q_MUL;
                    end
                end

                ST_MAC_WAIT:
                begin
                    mm_a_reg  <= q_rdata_reg;
                    mm_b_reg  <= den_rdata_reg;
                    state_reg <= ST_MAC_MUL;
                end

                ST_MAC_MUL:
                begin
                    if (mm_stat.done)
                    begin
                        s_reg     <= s_acc;
                        j_reg     <= jp1;
                        state_reg <= ST_ROW;
                    end
                end

                ST_NUM_WAIT:
                begin
                    mm_a_reg  <= COEFF_BITS'(1);
                    mm_b_reg  <= num_rdata_reg;
                    state_reg <= ST_NUM_MUL;
                end

                ST_NUM_MUL:
                begin
                    if (mm_stat.done)
                    begin
                        mm_a_reg  <= t0_reg;
                        mm_b_reg  <= v_sub;
                        state_reg <= ST_Q_MUL;
                    end
                end

                ST_Q_MUL:
                begin
                    if (mm_stat.done)
                    begin
                        i_reg     <= i_reg + CW'(1);
                        j_reg     <= '0;
                        s_reg     <= '0;
                        state_reg <= ST_ROW;
                    end
                end

                ST_QCLR:
                begin
                    if (i_reg == cw_max - CW'(1))
                    begin
                        res_status_reg  <= STATUS_OK;
                        last_status_reg <= STATUS_OK;
                        res_coeff_reg   <= '0;
                        state_reg       <= ST_PUT;
                    end
                    else
                        i_reg <= i_reg + CW'(1);
                end

                ST_PUT:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        status_reg    <= res_status_reg;
                        coeff_out_reg <= res_coeff_reg;
                        state_reg     <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign coeff_out = coeff_out_reg;

endmodule

>>> src/psdm_modmul.sv
`timescale 1ns / 1ps
// bit-serial modular multiplier: result = a * b mod m, one bit of b per cycle
// depends on psdm_pkg

module psdm_modmul #(
    parameter int COEFF_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  go,
    input  logic [COEFF_BITS-1:0] a,
    input  logic [COEFF_BITS-1:0] b,
    input  logic [COEFF_BITS-1:0] m,
    output logic [COEFF_BITS-1:0] result,
    output psdm_pkg::mm_stat_t    stat
);
    import psdm_pkg::*;

    localparam int SW = $clog2(COEFF_BITS);

    logic [COEFF_BITS-1:0] a_reg;
    logic [COEFF_BITS-1:0] b_reg;
    logic [COEFF_BITS-1:0] r_reg;
    logic [SW-1:0]         cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [WORD_BITS-1:0]  dbl;
    logic [WORD_BITS-1:0]  addend;
    logic [COEFF_BITS-1:0] r_next;

    // double, then add a when the current bit of b is set
    always_comb
    begin
        dbl    = add_m(WORD_BITS'(r_reg), WORD_BITS'(r_reg), WORD_BITS'(m));
        addend = b_reg[COEFF_BITS-1] ? WORD_BITS'(a_reg) : '0;
        r_next = COEFF_BITS'(add_m(dbl, addend, WORD_BITS'(m)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg    <= '0;
            b_reg    <= '0;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (go)
        begin
            a_reg    <= a;
            b_reg    <= b;
            r_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            r_reg   <= r_next;
            b_reg   <= {b_reg[COEFF_BITS-2:0], 1'b0};
            cnt_reg <= cnt_reg + SW'(1);
            if (cnt_reg == SW'(COEFF_BITS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign result    = r_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> src/psdm_checker.sv
`timescale 1ns / 1ps
// port-level checks for the power series divider, bound to the top level
// depends on psdm_pkg and power_series_divide_mod_n_unit

module psdm_checker #(
    parameter int COEFF_BITS = 64
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_stall,
    input psdm_pkg::op_t         op,
    input logic                  out_valid,
    input logic                  out_stall,
    input psdm_pkg::status_t     status,
    input logic [COEFF_BITS-1:0] coeff_out
);
    import psdm_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(coeff_out))
        else $error("stalled result changed");

    // no status code beyond the defined ones
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (status == STATUS_OK || status == STATUS_DEN_ZERO ||
                       status == STATUS_NO_INV))
        else $error("undefined status code");

    // a compute transfer keeps the block busy in the next cycle
    a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && op == OP_COMPUTE |=> in_stall)
        else $error("compute did not occupy the block");

    // a load transfer leaves the block ready for the next item
    a_load_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && (op == OP_LOAD_NUM || op == OP_LOAD_DEN) |=> !in_stall)
        else $error("load stalled the input");

endmodule

bind power_series_divide_mod_n_unit psdm_checker #(
    .COEFF_BITS (COEFF_BITS)
) u_psdm_checker (.*);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// self-checking bench for power_series_divide_mod_n_unit: directed and random
// load/compute/read traffic, scoreboard predicts quotient series mod m; uses psdm_pkg

module tb_top;
    import psdm_pkg::*;

    localparam int MAXT = 256;

    class quotient_scoreboard;
        logic [63:0] modulus;
        logic [8:0]  terms;
        logic [63:0] num_coef [MAXT];
        logic [63:0] den_coef [MAXT];
        logic [63:0] quo_coef [MAXT];
        status_t     last_status;
        bit          quo_written;
        status_t     exp_status [$];
        logic [63:0] exp_coeff [$];
        int          errors;
        int          n_results;
        int          n_computes;

        function new();
            modulus = 64'd2;
            terms = 9'd1;
            foreach (num_coef[i]) num_coef[i] = '0;
            foreach (den_coef[i]) den_coef[i] = '0;
            foreach (quo_coef[i]) quo_coef[i] = '0;
            last_status = STATUS_OK;
            quo_written = 0;
            errors = 0;
            n_results = 0;
            n_computes = 0;
        endfunction

        function void set_reg(cfg_idx_t idx, logic [63:0] data);
            if (idx == REG_MODULUS)
                modulus = data;
            else
                terms = data[8:0];
        endfunction

        function logic [63:0] mul_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            return 64'(p % {64'd0, m});
        endfunction

        function logic [63:0] sub_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
            return (a >= b) ? a - b : a - b + m;
        endfunction

        function logic [63:0] add_mod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
            logic [64:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s >= {1'b0, m})
                s = s - {1'b0, m};
            return s[63:0];
        endfunction

        // extended euclid, inverse kept reduced mod m
        function bit invert(logic [63:0] a, logic [63:0] m, output logic [63:0] inv);
            logic [63:0] r0, r1, r2, t0, t1, t2, q;
            r0 = m; r1 = a; t0 = 0; t1 = 1 % m;
            inv = 0;
            while (r1 != 0)
            begin
                q = r0 / r1;
                r2 = r0 - q * r1;
                t2 = sub_mod(t0, mul_mod(q % m, t1, m), m);
                r0 = r1; r1 = r2;
                t0 = t1; t1 = t2;
            end
            if (r0 != 1)
                return 0;
            inv = t0;
            return 1;
        endfunction

        function status_t divide_series(logic [8:0] nlen, logic [8:0] dlen_in);
            logic [63:0] m, d0, inv, s, v;
            int n, plen, dlen, l;
            m = (modulus < 2) ? 64'd2 : modulus;
            n = (terms > MAXT) ? MAXT : terms;
            dlen = (dlen_in > MAXT) ? MAXT : dlen_in;
            if (n == 0 || dlen == 0)
                return STATUS_DEN_ZERO;
            d0 = den_coef[0] % m;
            if (d0 == 0)
                return STATUS_DEN_ZERO;
            if (nlen == 0)
            begin
                foreach (quo_coef[i]) quo_coef[i] = '0;
                quo_written = 1;
                return STATUS_OK;
            end
            if (!invert(d0, m, inv))
                return STATUS_NO_INV;
            plen = (nlen > n) ? n : nlen;
            if (dlen > n)
                dlen = n;
            for (int i = 0; i < n; i++)
            begin
                l = (i < dlen - 1) ? i : dlen - 1;
                s = 0;
                for (int j = 0; j < l; j++)
                    s = add_mod(s, mul_mod(den_coef[j+1] % m, quo_coef[i-1-j], m), m);
                v = (i < plen) ? num_coef[i] % m : 64'd0;
                quo_coef[i] = mul_mod(sub_mod(v, s, m), inv, m);
            end
            for (int i = n; i < MAXT; i++)
                quo_coef[i] = '0;
            quo_written = 1;
            return STATUS_OK;
        endfunction

        function void note_item(op_t o, logic [7:0] idx, logic [63:0] val,
                                logic [8:0] nlen, logic [8:0] dlen);
            case (o)
                OP_LOAD_NUM: num_coef[idx] = val;
                OP_LOAD_DEN: den_coef[idx] = val;
                OP_COMPUTE:
                begin
                    last_status = divide_series(nlen, dlen);
                    n_computes++;
                    exp_status.push_back(last_status);
                    exp_coeff.push_back(64'd0);
                end
                default:
                begin
                    exp_status.push_back(last_status);
                    exp_coeff.push_back(quo_coef[idx]);
                end
            endcase
        endfunction

        function void check_result(status_t st, logic [63:0] co);
            status_t     es;
            logic [63:0] ec;
            n_results++;
            if (exp_status.size() == 0)
            begin
                $display("%0t: unexpected result status=%0d coeff=%h", $time, st, co);
                errors++;
                return;
            end
            es = exp_status.pop_front();
            ec = exp_coeff.pop_front();
            if (st !== es)
            begin
                $display("%0t: status mismatch expected %0d actual %0d", $time, es, st);
                errors++;
            end
            if (co !== ec)
            begin
                $display("%0t: coeff_out mismatch expected %h actual %h", $time, ec, co);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_idx_t    cfg_index;
    logic [63:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    op_t         op;
    logic [7:0]  coeff_index;
    logic [63:0] coeff_value;
    logic [8:0]  num_len;
    logic [8:0]  den_len;
    logic        out_valid;
    logic        out_stall;
    status_t     status;
    logic [63:0] coeff_out;

    quotient_scoreboard sb;
    int burst_left;
    int cycle_count;

    power_series_divide_mod_n_unit #(.MAX_TERMS(MAXT), .COEFF_BITS(64)) uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .op(op), .coeff_index(coeff_index),
        .coeff_value(coeff_value), .num_len(num_len), .den_len(den_len),
        .out_valid(out_valid), .out_stall(out_stall), .status(status),
        .coeff_out(coeff_out)
    );

    initial clk = 0;
    always #10 clk = ~clk;

    // receiver stall pattern changes with bits 9:8 of the cycle count, one stretch with no stall
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        case (cycle_count[9:8])
            2'd0: out_stall <= 1'b0;
            2'd1: out_stall <= ($urandom_range(0, 2) == 0);
            2'd2: out_stall <= cycle_count[4] & cycle_count[3];
            default: out_stall <= 1'($urandom_range(0, 1));
        endcase
    end

    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result(status, coeff_out);

    task automatic send_item(op_t o, logic [7:0] idx, logic [63:0] val,
                             logic [8:0] nlen, logic [8:0] dlen);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 10);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        op <= o;
        coeff_index <= idx;
        coeff_value <= val;
        num_len <= nlen;
        den_len <= dlen;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_item(o, idx, val, nlen, dlen);
    endtask

    task automatic cfg_write(cfg_idx_t idx, logic [63:0] data);
        in_valid <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(idx, data);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // all results in, then let a trailing load retire
    task automatic wait_idle();
        in_valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (sb.exp_status.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [63:0] pick_modulus();
        logic [63:0] m;
        case ($urandom_range(0, 4))
            0: m = 64'hFFFF_FFFF_FFFF_FFFF;
            1: m = {$urandom, $urandom} | 64'd2;
            2: m = 64'd1 << $urandom_range(1, 63);
            3: m = $urandom_range(2, 1000);
            default: m = 64'hFFFF_FFFF_FFFF_FFC5;
        endcase
        return m;
    endfunction

    task automatic random_phase(int count);
        int          n;
        int          k;
        logic [63:0] v;
        logic [7:0]  idx;
        n = sb.terms;
        v = {$urandom, $urandom};
        send_item(OP_LOAD_DEN, 8'd0, v | 64'd1, 9'd0, 9'd0);
        for (k = 0; k < count; k++)
        begin
            v = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : {$urandom, $urandom};
            idx = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, n + 1));
            case ($urandom_range(0, 9))
                0, 1, 2: send_item(OP_LOAD_NUM, idx, v, 9'($urandom), 9'($urandom));
                3, 4:    send_item(OP_LOAD_DEN, idx, v, 9'($urandom), 9'($urandom));
                5, 6:
                    if ($urandom_range(0, 3) == 0)
                        send_item(OP_COMPUTE, 8'($urandom), v, 9'($urandom), 9'($urandom));
                    else
                        send_item(OP_COMPUTE, idx, v, 9'($urandom_range(0, n + 1)),
                                  9'($urandom_range(1, n + 1)));
                default:
                    if (sb.quo_written)
                        send_item(OP_READ, idx, v, 9'($urandom), 9'($urandom));
                    else
                        send_item(OP_LOAD_NUM, idx, v, 9'($urandom), 9'($urandom));
            endcase
        end
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        cycle_count = 0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_MODULUS;
        cfg_data = '0;
        in_valid = 1'b0;
        op = OP_LOAD_NUM;
        coeff_index = '0;
        coeff_value = '0;
        num_len = '0;
        den_len = '0;
        out_stall = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // modulus below two acts as two, zero terms is a denominator error
        cfg_write(REG_MODULUS, 64'd1);
        cfg_write(REG_TERMS, 64'd0);
        send_item(OP_LOAD_DEN, 8'd0, 64'd3, 9'd0, 9'd0);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd1, 9'd1);
        wait_idle();
        cfg_write(REG_MODULUS, 64'd12);
        cfg_write(REG_TERMS, 64'd4);
        send_item(OP_LOAD_DEN, 8'd0, 64'd24, 9'd0, 9'd0);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd4, 9'd4);      // leading zero mod m
        send_item(OP_LOAD_DEN, 8'd0, 64'd5, 9'd0, 9'd0);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd4, 9'd0);      // empty denominator
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd0, 9'd3);      // empty numerator, all zero
        send_item(OP_READ, 8'd2, 64'd0, 9'd0, 9'd0);
        send_item(OP_LOAD_DEN, 8'd0, 64'd4, 9'd0, 9'd0);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd4, 9'd4);      // no inverse, store kept
        send_item(OP_READ, 8'd0, 64'd0, 9'd0, 9'd0);
        send_item(OP_LOAD_DEN, 8'd0, 64'd7, 9'd0, 9'd0);
        send_item(OP_LOAD_DEN, 8'd1, 64'hFFFF_FFFF_FFFF_FFFF, 9'd0, 9'd0);
        send_item(OP_LOAD_NUM, 8'd0, 64'hFFFF_FFFF_FFFF_FFFF, 9'd0, 9'd0);
        send_item(OP_LOAD_NUM, 8'd255, 64'hFFFF_FFFF_FFFF_FFFF, 9'd0, 9'd0);
        send_item(OP_LOAD_DEN, 8'd255, 64'd9, 9'd0, 9'd0);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd511, 9'd511);  // oversize lengths
        send_item(OP_READ, 8'd3, 64'd0, 9'd0, 9'd0);
        send_item(OP_READ, 8'd255, 64'd0, 9'd0, 9'd0);
        wait_idle();
        // widest settings, short denominator keeps the long run cheap
        cfg_write(REG_MODULUS, 64'hFFFF_FFFF_FFFF_FFFF);
        cfg_write(REG_TERMS, 64'd511);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd256, 9'd1);
        send_item(OP_READ, 8'd0, 64'd0, 9'd0, 9'd0);
        send_item(OP_READ, 8'd255, 64'd0, 9'd0, 9'd0);
        wait_idle();
        cfg_write(REG_TERMS, 64'd256);
        send_item(OP_COMPUTE, 8'd0, 64'd0, 9'd256, 9'd2);
        send_item(OP_READ, 8'd200, 64'd0, 9'd0, 9'd0);

        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            cfg_write(REG_MODULUS, pick_modulus());
            cfg_write(REG_TERMS, 64'($urandom_range(1, 12)));
            random_phase(20);
        end

        wait_idle();
        repeat (20) @(posedge clk);
        $display("run covered %0d results and %0d computes over several moduli and lengths",
                 sb.n_results, sb.n_computes);
        if (sb.errors == 0 && sb.exp_status.size() == 0)
            $display("PASS power_series_divide_mod_n_unit");
        else
            $display("FAIL power_series_divide_mod_n_unit");
        $finish;
    end

    initial
    begin
        #(400_000_000);
        $display("FAIL power_series_divide_mod_n_unit");
        $finish;
    end

endmodule

>>> filelist.f
src/psdm_pkg.sv
src/psdm_modmul.sv
src/power_series_divide_mod_n_unit.sv
src/psdm_checker.sv
tb/sv/tb_top.sv
